@@ rtl/bur_pkg.sv @@
// Shared types and constants of the bounded uniform reducer.
// No dependencies; every module of the block imports this package.
package bur_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned HALF_W = WORD_W / 2;
  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Range after reset; its threshold is zero.
  localparam word_t RANGE_RESET = word_t'(1);
  localparam cnt_t  CNT_LAST    = cnt_t'(WORD_W - 1);

  // Four 16x16 partial products of one 32x32 multiply.
  typedef struct packed {
    word_t ll;
    word_t lh;
    word_t hl;
    word_t hh;
  } pprod_t;

  // Threshold unit status seen by the top level.
  typedef struct packed {
    logic  busy;
    word_t threshold;
  } thr_status_t;

endpackage

@@ rtl/bur_thresh_div.sv @@
// Iterative remainder unit: computes 2^32 mod range, one bit per cycle.
// Depends on bur_pkg.
module bur_thresh_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bur_pkg::word_t      range_i,
  output bur_pkg::thr_status_t status_o
);
  import bur_pkg::*;

  logic  busy_q, busy_d;
  cnt_t  cnt_q, cnt_d;
  word_t rem_q, rem_d;
  word_t div_q, div_d;
  word_t thr_q, thr_d;

  logic [WORD_W:0] shifted;
  word_t           diff;
  word_t           rem_next;

  // One restoring step: shift in a zero bit of the dividend
  assign shifted  = {rem_q, 1'b0};
  assign diff     = shifted[WORD_W-1:0] - div_q;
  assign rem_next = (shifted >= {1'b0, div_q}) ? diff : shifted[WORD_W-1:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    thr_d  = thr_q;
    if (start_i) begin
      div_d = range_i;
      cnt_d = '0;
      rem_d = word_t'(1);
      // ranges of zero and one need no division
      if (range_i <= word_t'(1)) begin
        thr_d  = '0;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = rem_next;
      cnt_d = cnt_q + cnt_t'(1);
      if (cnt_q == CNT_LAST) begin
        thr_d  = rem_next;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      thr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      thr_q  <= thr_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign status_o.busy      = busy_q;
  assign status_o.threshold = thr_q;

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < div_q)
    else $error("remainder not below divisor");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && range_i > word_t'(1) |=> busy_q)
    else $error("division did not start");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && cnt_q == CNT_LAST |=> !busy_q)
    else $error("division overran");
`endif
endmodule

@@ rtl/bur_mul_pipe.sv @@
// Two-stage 32x32 multiplier: partial products, then the 64-bit sum.
// Depends on bur_pkg.
module bur_mul_pipe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           up_valid_i,
  output logic           up_ready_o,
  input  bur_pkg::word_t word_i,
  input  bur_pkg::word_t range_i,
  output logic           dn_valid_o,
  input  logic           dn_ready_i,
  output bur_pkg::prod_t prod_o
);
  import bur_pkg::*;

  logic   s1_valid_q, s2_valid_q;
  logic   s1_en, s2_en;
  pprod_t s1_pp_q, s1_pp_d;
  prod_t  s2_prod_q, s2_prod_d;
  half_t  a_lo, a_hi, b_lo, b_hi;

  // a stage loads when empty or when its contents move on
  assign s2_en      = !s2_valid_q || dn_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign up_ready_o = s1_en;

  // stage 1: partial products
  assign a_lo = word_i[HALF_W-1:0];
  assign a_hi = word_i[WORD_W-1:HALF_W];
  assign b_lo = range_i[HALF_W-1:0];
  assign b_hi = range_i[WORD_W-1:HALF_W];

  always_comb begin
    s1_pp_d.ll = word_t'(a_lo) * word_t'(b_lo);
    s1_pp_d.lh = word_t'(a_lo) * word_t'(b_hi);
    s1_pp_d.hl = word_t'(a_hi) * word_t'(b_lo);
    s1_pp_d.hh = word_t'(a_hi) * word_t'(b_hi);
  end

  // stage 2: align and sum
  assign s2_prod_d = prod_t'(s1_pp_q.ll)
                   + (prod_t'(s1_pp_q.lh) << HALF_W)
                   + (prod_t'(s1_pp_q.hl) << HALF_W)
                   + (prod_t'(s1_pp_q.hh) << WORD_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= up_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && up_valid_i) s1_pp_q <= s1_pp_d;
    if (s2_en && s1_valid_q) s2_prod_q <= s2_prod_d;
  end

  assign dn_valid_o = s2_valid_q;
  assign prod_o     = s2_prod_q;

endmodule

@@ rtl/bounded_uniform_reducer.sv @@
// Top level of the bounded uniform reducer: range register, threshold unit,
// multiply pipeline and the reject/output stage. Depends on bur_pkg,
// bur_thresh_div and bur_mul_pipe.

// Maps uniform 32-bit words onto [0, range) without bias by multiply and
// reject: each request gives one result, flagged accepted with the high half
// of word*range, or rejected with value 0 when the low half falls below
// 2^32 mod range. Requests flow one per cycle, while the output is not stalled
// and no threshold is being computed, through three register stages (partial
// products, product sum, compare and select). A write of the range starts the
// remainder unit, which works one bit a cycle for ranges above one; requests
// are stalled meanwhile. Ranges of zero and one always accept and give 0.
module bounded_uniform_reducer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  bur_pkg::word_t cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bur_pkg::word_t random_word_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           accepted_o,
  output bur_pkg::word_t bounded_value_o
);
  import bur_pkg::*;

  word_t       range_q;
  thr_status_t thr;
  logic        pipe_ready;
  logic        p_valid;
  prod_t       p_prod;
  logic        s3_en;
  logic        out_valid_q;
  logic        accepted_q, accepted_d;
  word_t       value_q, value_d;

  // range register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_RESET;
    end else if (cfg_we_i) begin
      range_q <= cfg_wdata_i;
    end
  end

  bur_thresh_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_we_i),
    .range_i  (cfg_wdata_i),
    .status_o (thr)
  );

  // hold requests off while the threshold is being computed
  assign in_stall_o = thr.busy || !pipe_ready;

  bur_mul_pipe u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i && !thr.busy),
    .up_ready_o (pipe_ready),
    .word_i     (random_word_i),
    .range_i    (range_q),
    .dn_valid_o (p_valid),
    .dn_ready_i (s3_en),
    .prod_o     (p_prod)
  );

  // stage 3: reject test and output register
  assign s3_en = !out_valid_q || !out_stall_i;

  always_comb begin
    if (p_prod[WORD_W-1:0] < thr.threshold) begin
      accepted_d = 1'b0;
      value_d    = '0;
    end else begin
      accepted_d = 1'b1;
      value_d    = p_prod[PROD_W-1:WORD_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_en) begin
      out_valid_q <= p_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && p_valid) begin
      accepted_q <= accepted_d;
      value_q    <= value_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = accepted_q;
  assign bounded_value_o = value_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr.busy |-> in_stall_o)
    else $error("request taken during threshold update");
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> bounded_value_o == '0)
    else $error("rejected result carries a value");
  a_value_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_q != '0 |-> bounded_value_o < range_q)
    else $error("result not below range");
  a_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_q == '0 |-> accepted_o && bounded_value_o == '0)
    else $error("zero range result wrong");
`endif
endmodule

@@ tb/bur_checker.sv @@
// Result checker for the bounded uniform reducer: follows range writes, predicts
// each result from the accepted requests and compares results in order.
// Depends on bur_pkg for the word and product types.
module bur_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  bur_pkg::word_t cfg_wdata_i,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  bur_pkg::word_t random_word_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  logic           accepted_i,
  input  bur_pkg::word_t bounded_value_i,
  output int             errors_o,
  output int             pending_o
);
  import bur_pkg::*;

  // One predicted draw: accept flag and bounded value
  typedef struct packed {
    logic  accepted;
    word_t value;
  } draw_t;

  word_t range_q  = RANGE_RESET;
  word_t thresh_q = '0;
  draw_t draws_q[$];
  int    errors   = 0;

  // 2^32 mod r, formed as (2^32 - r) mod r in word arithmetic
  function automatic word_t range_remainder(input word_t r);
    word_t wrapped;
    if (r == '0) return '0;
    wrapped = word_t'(0) - r;
    return wrapped % r;
  endfunction

  // Multiply, then reject when the low half falls below the threshold
  function automatic draw_t bound_word(input word_t w, input word_t r, input word_t thr);
    prod_t prod;
    draw_t d;
    prod = prod_t'(w) * prod_t'(r);
    if (prod[WORD_W-1:0] < thr) begin
      d.accepted = 1'b0;
      d.value    = '0;
    end else begin
      d.accepted = 1'b1;
      d.value    = prod[PROD_W-1:WORD_W];
    end
    return d;
  endfunction

  // Track config, compare finished results, queue predictions for new requests
  always @(posedge clk_i or negedge rst_ni) begin
    draw_t want;
    if (!rst_ni) begin
      range_q  = RANGE_RESET;
      thresh_q = '0;
      draws_q.delete();
    end else begin
      if (cfg_we_i) begin
        range_q  = cfg_wdata_i;
        thresh_q = range_remainder(cfg_wdata_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (draws_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: accepted %0b value %h", $time, accepted_i,
                   bounded_value_i);
        end else begin
          want = draws_q.pop_front();
          if (accepted_i !== want.accepted) begin
            errors++;
            $display("%0t: accepted mismatch: expected %0b actual %0b", $time,
                     want.accepted, accepted_i);
          end
          if (bounded_value_i !== want.value) begin
            errors++;
            $display("%0t: bounded_value mismatch: expected %h actual %h", $time,
                     want.value, bounded_value_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        draws_q.push_back(bound_word(random_word_i, range_q, thresh_q));
      end
    end
    errors_o  <= errors;
    pending_o <= draws_q.size();
  end

endmodule

@@ tb/tb_bounded_uniform_reducer.sv @@
// Testbench top for the bounded uniform reducer: clock, reset, range writes,
// request stimulus with idle and stall phases, and the verdict.
// Depends on bur_pkg, bounded_uniform_reducer and bur_checker.
module tb_bounded_uniform_reducer;
  import bur_pkg::*;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int HOLD_CYCLES     = 150;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PRESSURE_PHASE  = 4;

  logic  clk_i         = 1'b0;
  logic  rst_ni        = 1'b0;
  logic  cfg_we_i      = 1'b0;
  word_t cfg_wdata_i   = '0;
  logic  in_valid_i    = 1'b0;
  logic  in_stall_o;
  word_t random_word_i = '0;
  logic  out_valid_o;
  logic  out_stall_i   = 1'b0;
  logic  accepted_o;
  word_t bounded_value_o;

  int errors;
  int pending;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_ack     = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  bounded_uniform_reducer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .random_word_i  (random_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .bounded_value_o(bounded_value_o)
  );

  bur_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .random_word_i  (random_word_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_i     (accepted_o),
    .bounded_value_i(bounded_value_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // Result side: a requested long hold first, else random stalls at the phase rate
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog: too long without any request, result or range write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[bounded_uniform_reducer] ERROR");
      $finish;
    end
  end

  // Idle pattern: none, sender idle, receiver stalling, both lightly
  task automatic set_pace(input int mode);
    case (mode)
      0: begin
        tx_idle_pct  = 0;
        rx_stall_pct <= 0;
      end
      1: begin
        tx_idle_pct  = 75;
        rx_stall_pct <= 0;
      end
      2: begin
        tx_idle_pct  = 0;
        rx_stall_pct <= 75;
      end
      default: begin
        tx_idle_pct  = 9;
        rx_stall_pct <= 9;
      end
    endcase
  endtask

  // Offer one request and hold it until the block takes it
  task automatic push_word(input word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    random_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Range writes only happen with the pipeline empty
  task automatic set_range(input word_t r);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly uniform words, some corner words
  function automatic word_t pick_word();
    if ($urandom_range(7) != 0) return $urandom;
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1);
      default: return 32'h8000_0000;
    endcase
  endfunction

  // Range per phase; large ranges just above 2^31 reject about half the words
  function automatic word_t pick_range(input int p);
    case (p % 6)
      0: return $urandom;
      1: return word_t'($urandom_range(1000, 2));
      2: return 32'h8000_0000 | $urandom;
      3: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return word_t'(1);
          2:       return '1;
          default: return 32'h8000_0001;
        endcase
      end
      4: return $urandom >> $urandom_range(31, 0);
      default: return 32'hFFFF_FFFF - word_t'($urandom_range(32'hFFFF));
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_pace(0);

    // range of one after reset: always accepted, value 0
    push_word('0);
    push_word('1);
    push_word(32'h1234_5678);

    // range of zero: always accepted, value 0
    set_range('0);
    push_word('0);
    push_word('1);

    // widest range: word 0 is the only reject
    set_range('1);
    push_word('0);
    push_word(word_t'(1));
    push_word('1);
    push_word(32'h8000_0000);

    // range 3: threshold 1, word 0 rejected
    set_range(word_t'(3));
    push_word('0);
    push_word(32'h5555_5556);
    push_word('1);

    // range just above 2^31: threshold 0x7fffffff, low half right at the edge
    set_range(32'h8000_0001);
    push_word('0);
    push_word(word_t'(1));
    push_word(word_t'(2));
    push_word('1);

    // random phases, each with its own range and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      set_range(pick_range(p));
      set_pace(p % 4);
      if (p == PRESSURE_PHASE) hold_req <= hold_req + 1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) push_word(pick_word());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[bounded_uniform_reducer] OK");
    end else begin
      $display("[bounded_uniform_reducer] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bur_pkg.sv
rtl/bur_thresh_div.sv
rtl/bur_mul_pipe.sv
rtl/bounded_uniform_reducer.sv
tb/bur_checker.sv
tb/tb_bounded_uniform_reducer.sv
